@@ rtl/wspr_type1_tone_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// WSPR type-1 tone encoder assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef WSPR_TYPE1_TONE_ENCODER_MACROS_SVH
`define WSPR_TYPE1_TONE_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WTE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wte assertion failed");
// next-cycle implication
`define WTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wte assertion failed");
`else
`define WTE_ASSERT(lbl, ante, cons)
`define WTE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/wte_pkg.sv @@
// ----------------------------------------------------------------------------
// wte_pkg
// Shared types and constants of the WSPR type-1 tone encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wte_pkg;

  localparam int NUM_WORDS   = 6;
  localparam int WORD_W      = 64;
  localparam int MSG_W       = 50;
  localparam int NUM_SYMBOLS = 162;

  localparam logic [2:0] LAST_WORD = 3'(NUM_WORDS - 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CALL = 2'd1,
    ST_BAD_LOC  = 2'd2
  } status_e;

  typedef struct packed {
    logic [47:0]        call_chars;
    logic [3:0]         call_length;
    logic [31:0]        locator_chars;
    logic [3:0]         locator_length;
    logic signed [7:0]  tx_power;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  tone_word;
    logic [2:0]         word_index;
    status_e            status;
    logic               last;
  } out_req_t;

  // per-column codes after alignment and checking
  typedef struct packed {
    logic [5:0] c0;
    logic [5:0] c1;
    logic [3:0] c2;
    logic [4:0] c3;
    logic [4:0] c4;
    logic [4:0] c5;
    logic [4:0] loc_a;
    logic [4:0] loc_b;
    logic [3:0] loc_c;
    logic [3:0] loc_d;
    logic [5:0] power;
    status_e    status;
  } dec_t;

endpackage

@@ rtl/wte_decode.sv @@
// ----------------------------------------------------------------------------
// wte_decode
// Callsign alignment and column coding, locator checks, power rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wte_decode (
  input  wte_pkg::in_req_t req_i,
  output wte_pkg::dec_t    dec_o
);

  function automatic logic [7:0] upcase(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
  endfunction

  function automatic logic is_dig(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ch >= "A" && ch <= "Z";
  endfunction

  // {ok, code}: digits 0..9, letters 10..35, space 36 if allowed
  function automatic logic [6:0] code_alnum(input logic [7:0] ch, input logic sp_ok);
    logic [7:0] v;
    v = 8'd0;
    if (is_dig(ch)) begin
      v = ch - "0";
      return {1'b1, v[5:0]};
    end
    if (is_alpha(ch)) begin
      v = ch - "A" + 8'd10;
      return {1'b1, v[5:0]};
    end
    if (sp_ok && ch == " ") begin
      return {1'b1, 6'd36};
    end
    return 7'd0;
  endfunction

  // {ok, code}: letters 0..25, space 26
  function automatic logic [5:0] code_letter(input logic [7:0] ch);
    logic [7:0] v;
    v = ch - "A";
    if (is_alpha(ch)) begin
      return {1'b1, v[4:0]};
    end
    if (ch == " ") begin
      return {1'b1, 5'd26};
    end
    return 6'd0;
  endfunction

  logic [7:0] t [6];
  logic [7:0] col [6];
  logic       shift, len_ok, call_bad, loc_bad;
  logic [6:0] k0, k1;
  logic [5:0] k3, k4, k5;
  logic [7:0] la, lb, lc, ld;
  logic [7:0] d2;
  logic [5:0] pclamp, prem, pw;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      t[i] = (4'(i) < req_i.call_length) ? upcase(req_i.call_chars[47 - 8*i -: 8]) : " ";
    end
    len_ok = (req_i.call_length >= 4'd3) && (req_i.call_length <= 4'd6);
    // a callsign without a digit in the third column moves right by one
    shift  = !is_dig(t[2]);
    col[0] = shift ? " " : t[0];
    for (int i = 1; i < 6; i++) begin
      col[i] = shift ? t[i-1] : t[i];
    end
    k0 = code_alnum(col[0], 1'b1);
    k1 = code_alnum(col[1], 1'b0);
    k3 = code_letter(col[3]);
    k4 = code_letter(col[4]);
    k5 = code_letter(col[5]);
    d2 = col[2] - "0";
    call_bad = !len_ok || (shift && req_i.call_length == 4'd6) || !is_dig(col[2]) ||
               !k0[6] || !k1[6] || !k3[5] || !k4[5] || !k5[5];

    la = upcase(req_i.locator_chars[31:24]) - "A";
    lb = upcase(req_i.locator_chars[23:16]) - "A";
    lc = req_i.locator_chars[15:8] - "0";
    ld = req_i.locator_chars[7:0] - "0";
    loc_bad = (req_i.locator_length != 4'd4) || (la > 8'd17) || (lb > 8'd17) ||
              (lc > 8'd9) || (ld > 8'd9);

    if ($signed(req_i.tx_power) < 8'sd0) begin
      pclamp = 6'd0;
    end else if ($signed(req_i.tx_power) > 8'sd60) begin
      pclamp = 6'd60;
    end else begin
      pclamp = req_i.tx_power[5:0];
    end
    // remainder by ten: at most six subtractions for 0..60
    prem = pclamp;
    for (int i = 0; i < 6; i++) begin
      if (prem >= 6'd10) begin
        prem = prem - 6'd10;
      end
    end
    // round to an ending of 0, 3 or 7
    case (prem) inside
      6'd1, 6'd4, 6'd8: pw = pclamp - 6'd1;
      6'd2, 6'd6, 6'd9: pw = pclamp + 6'd1;
      6'd5:             pw = pclamp + 6'd2;
      default:          pw = pclamp;
    endcase

    dec_o.c0     = k0[5:0];
    dec_o.c1     = k1[5:0];
    dec_o.c2     = d2[3:0];
    dec_o.c3     = k3[4:0];
    dec_o.c4     = k4[4:0];
    dec_o.c5     = k5[4:0];
    dec_o.loc_a  = la[4:0];
    dec_o.loc_b  = lb[4:0];
    dec_o.loc_c  = lc[3:0];
    dec_o.loc_d  = ld[3:0];
    dec_o.power  = pw;
    dec_o.status = call_bad ? wte_pkg::ST_BAD_CALL :
                   loc_bad  ? wte_pkg::ST_BAD_LOC  : wte_pkg::ST_OK;
  end

endmodule

@@ rtl/wte_fec.sv @@
// ----------------------------------------------------------------------------
// wte_fec
// K=32 rate-1/2 convolutional code, bit-reverse interleave, sync merge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wte_fec (
  input  logic [wte_pkg::MSG_W-1:0]                          msg_i,
  output logic [wte_pkg::NUM_WORDS-1:0][wte_pkg::WORD_W-1:0] words_o
);

  localparam int NSYM  = wte_pkg::NUM_SYMBOLS;
  localparam int NSTEP = NSYM / 2;
  localparam int TPW   = wte_pkg::WORD_W / 2;

  localparam logic [31:0] POLY_A = 32'hF2D05351;
  localparam logic [31:0] POLY_B = 32'hE4613C47;

  // sync bit of symbol s at index s
  localparam logic [0:NSYM-1] SYNC = {
    20'b11000000100011100010, 20'b01011110000000100101,
    20'b00000010110011010001, 20'b10100001101010101001,
    20'b00101100011010100010, 20'b00001001001110110011,
    20'b01000111000001010011, 20'b00000001101011000110,
    2'b00
  };

  logic [NSTEP-1:0] stream;
  logic [NSYM-1:0]  code, ilv;

  always_comb begin
    logic       pa, pb;
    logic [7:0] ib, r;
    int         k;
    // message bits, first bit first, then the zero tail
    for (int j = 0; j < NSTEP; j++) begin
      stream[j] = (j < wte_pkg::MSG_W) ? msg_i[wte_pkg::MSG_W - 1 - j] : 1'b0;
    end
    for (int i = 0; i < NSTEP; i++) begin
      pa = 1'b0;
      pb = 1'b0;
      for (int t = 0; t < 32; t++) begin
        if (i >= t) begin
          pa = pa ^ (POLY_A[t] & stream[i-t]);
          pb = pb ^ (POLY_B[t] & stream[i-t]);
        end
      end
      code[2*i]   = pa;
      code[2*i+1] = pb;
    end
    // fixed permutation: code bit k goes to the k-th bit-reversed address below NSYM
    ilv = '0;
    k   = 0;
    for (int i = 0; i < 256; i++) begin
      ib = 8'(i);
      for (int j = 0; j < 8; j++) begin
        r[7-j] = ib[j];
      end
      if (r < 8'(NSYM)) begin
        ilv[r] = code[k];
        k = k + 1;
      end
    end
    words_o = '0;
    for (int s = 0; s < NSYM; s++) begin
      words_o[s / TPW][2*(s % TPW) +: 2] = {ilv[s], SYNC[s]};
    end
  end

endmodule

@@ rtl/wspr_type1_tone_encoder.sv @@
// ----------------------------------------------------------------------------
// wspr_type1_tone_encoder
// Path: an accepted request is registered in S1, S2, S3 and S4 in turn, and its first word in S5.
// Throughput: one tone word per cycle while out_stall_i is low; six words per
//   valid message, one word per rejected message, set by the word serializer ahead of the output.
// Reset: rst_ni async active low clears all stage valids and the word counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wspr_type1_tone_encoder_macros.svh"

module wspr_type1_tone_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wte_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wte_pkg::out_req_t out_req_o
);

  // Pipeline:
  //   S1  character decode, column codes, checks, power rounding
  //   S2  partial packs: callsign head/tail, locator row/column
  //   S3  final packs (one constant multiply each), 50-bit message
  //   S4  convolutional code + interleave + sync -> six tone words, serializer
  //   S5  output register
  // Each stage moves when the one after it can take its request. S4 frees only
  // when its last word goes into S5, so the front stages fill up behind it.

  typedef logic [wte_pkg::NUM_WORDS-1:0][wte_pkg::WORD_W-1:0] words_t;

  // ---- S1 ----
  wte_pkg::dec_t dec_d, dec_q;
  logic          v1_q;

  wte_decode u_decode (
    .req_i (in_req_i),
    .dec_o (dec_d)
  );

  // ---- S2 ----
  logic [13:0]      hi_d, hi_q;
  logic [14:0]      lo_d, lo_q;
  logic [7:0]       row_d, row_q, col_d, col_q;
  logic [5:0]       pw2_q;
  wte_pkg::status_e st2_q;
  logic             v2_q;

  // ---- S3 ----
  logic [27:0]               n1_d;
  logic [14:0]               ng_d;
  logic [wte_pkg::MSG_W-1:0] msg_d, msg_q;
  wte_pkg::status_e          st3_q;
  logic                      v3_q;

  // ---- S4 ----
  words_t           words_d, words_q;
  wte_pkg::status_e st4_q;
  logic [2:0]       cnt_d, cnt_q;
  logic             v4_q;

  // ---- S5 ----
  wte_pkg::out_req_t out_d, out_q;
  logic              ov_q;

  // ---- flow control ----
  logic o_rdy, pop4, last4, free4, rdy3, rdy2, rdy1;

  assign o_rdy = !ov_q || !out_stall_i;
  assign pop4  = v4_q && o_rdy;
  assign last4 = (st4_q != wte_pkg::ST_OK) || (cnt_q == wte_pkg::LAST_WORD);
  assign free4 = !v4_q || (o_rdy && last4);
  assign rdy3  = !v3_q || free4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign in_stall_o = !rdy1;

  // S2: head = (c0*36 + c1)*10 + c2, tail = c3*729 + c4*27 + c5
  assign hi_d  = (14'(dec_q.c0) * 14'd36 + 14'(dec_q.c1)) * 14'd10 + 14'(dec_q.c2);
  assign lo_d  = 15'(dec_q.c3) * 15'd729 + 15'(dec_q.c4) * 15'd27 + 15'(dec_q.c5);
  assign row_d = 8'd179 - 8'(dec_q.loc_a) * 8'd10 - 8'(dec_q.loc_c);
  assign col_d = 8'(dec_q.loc_b) * 8'd10 + 8'(dec_q.loc_d);

  // S3: callsign = head*27^3 + tail; grid = row*180 + column.
  // Power+64 sits below 128, so the 22-bit field is just {grid, 1, power}.
  assign n1_d  = 28'(hi_q) * 28'd19683 + 28'(lo_q);
  assign ng_d  = 15'(row_q) * 15'd180 + 15'(col_q);
  assign msg_d = {n1_d, ng_d, 1'b1, pw2_q};

  wte_fec u_fec (
    .msg_i   (msg_q),
    .words_o (words_d)
  );

  // S4 word counter: restart on load, step on each word handed on
  always_comb begin
    cnt_d = cnt_q;
    if (free4) begin
      cnt_d = 3'd0;
    end else if (pop4) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  // rejected messages give one all-zero word with the error status
  always_comb begin
    out_d.status = st4_q;
    out_d.last   = last4;
    if (st4_q == wte_pkg::ST_OK) begin
      out_d.tone_word  = words_q[cnt_q];
      out_d.word_index = cnt_q;
    end else begin
      out_d.tone_word  = '0;
      out_d.word_index = 3'd0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ov_q  <= 1'b0;
      cnt_q <= 3'd0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (free4) begin
        v4_q <= v3_q;
      end
      if (o_rdy) begin
        ov_q <= pop4;
      end
      cnt_q <= cnt_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      dec_q <= dec_d;
    end
    if (rdy2) begin
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      row_q <= row_d;
      col_q <= col_d;
      pw2_q <= dec_q.power;
      st2_q <= dec_q.status;
    end
    if (rdy3) begin
      msg_q <= msg_d;
      st3_q <= st2_q;
    end
    if (free4) begin
      words_q <= words_d;
      st4_q   <= st3_q;
    end
    if (o_rdy) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_req_o   = out_q;

  // ---- assertions ----
  // an error message yields one cleared, final word
  `WTE_ASSERT(a_err_single, out_valid_o && out_req_o.status != wte_pkg::ST_OK, out_req_o.last && out_req_o.word_index == 3'd0 && out_req_o.tone_word == '0)
  // a good message ends on word five and only there
  `WTE_ASSERT(a_ok_last, out_valid_o && out_req_o.status == wte_pkg::ST_OK, out_req_o.last == (out_req_o.word_index == wte_pkg::LAST_WORD))
  // words of one message follow without a gap
  `WTE_ASSERT_NEXT(a_word_step, out_valid_o && !out_stall_i && !out_req_o.last, out_valid_o && out_req_o.word_index == $past(out_req_o.word_index) + 3'd1)

endmodule
